>>> design/assert_macros.svh
// assertion macros shared by the sorted key table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SKT_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKT_ASSERT(lbl, expr)
`define SKT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/skt_pkg.sv
// constants, codes and types of the sorted key table
package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int KEY_IN_W = 32;
  localparam int KEY_W = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int POS_W = $clog2(CAPACITY + 1);

  localparam logic CMD_SEARCH = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } skt_ctl_t;

endpackage

>>> design/skt_cell.sv
// one cell of the sorted chain: a stored key, its compare flags and the shift-up path
module skt_cell (
  input  logic              clk,
  input  skt_pkg::skt_ctl_t ctl,
  input  skt_pkg::pos_t     cell_idx,
  input  skt_pkg::pos_t     count,
  input  skt_pkg::key_t     req_key,
  input  skt_pkg::key_t     prev_key,
  input  logic              prev_lt,
  output skt_pkg::key_t     key_out,
  output logic              lt_out,
  output logic              eq_out,
  output logic              bnd_out
);

  skt_pkg::key_t key_r;
  skt_pkg::key_t key_nxt;
  logic          lt_r;
  logic          lt_nxt;
  logic          eq_r;
  logic          eq_nxt;
  logic          occ;

  assign occ     = (cell_idx < count);
  // first cell whose key is not below the request key
  assign bnd_out = prev_lt & ~lt_r;

  always_comb begin
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    key_nxt = key_r;
    if (ctl.cmp_en) begin
      lt_nxt = occ & (key_r < req_key);
      eq_nxt = occ & (key_r == req_key);
    end
    // cells at or above the insert point move up by one
    if (ctl.ins_en && !lt_r) begin
      key_nxt = bnd_out ? req_key : prev_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

  assign key_out = key_r;
  assign lt_out  = lt_r;
  assign eq_out  = eq_r;

endmodule

>>> design/skt_encoder.sv
// turns the one-hot boundary of the chain into a position and the found flag
module skt_encoder (
  input  logic [skt_pkg::CAPACITY:0]   bnd,
  input  logic [skt_pkg::CAPACITY-1:0] eq,
  output skt_pkg::pos_t                position,
  output logic                         found
);

  always_comb begin
    position = '0;
    found    = 1'b0;
    for (int i = 0; i <= skt_pkg::CAPACITY; i++) begin
      position = position | ({skt_pkg::POS_W{bnd[i]}} & skt_pkg::POS_W'(i));
    end
    for (int i = 0; i < skt_pkg::CAPACITY; i++) begin
      found = found | (bnd[i] & eq[i]);
    end
  end

endmodule

>>> design/sorted_key_table.sv
// sorted key table: ascending chain of key cells with search and insert
//
//   port group   dir  handshake          payload
//   in_*         in   in_valid/in_stall  in_cmd, in_key
//   out_*        out  out_valid/out_stall out_found, out_position, out_status
//   cfg_*        in   cfg_we             cfg_wdata (unique mode)
//
// a request passes capture, parallel compare in every cell, then
// boundary encode with the shift-up insert done in the same cycle
// a new request is taken the cycle after the previous result is loaded
// rst_n clears the entry count, the control state and out_valid and sets unique mode
// a stalled result holds the update stage until the output register frees
`include "assert_macros.svh"

module sorted_key_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [6:0]  out_position,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic                  unique_r;
  skt_pkg::pos_t         count_r;
  skt_pkg::pos_t         count_nxt;
  logic                  cmd_r;
  skt_pkg::key_t         req_key_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  skt_pkg::pos_t         out_pos_r;
  logic [1:0]            out_status_r;

  skt_pkg::skt_ctl_t                 ctl;
  skt_pkg::key_t                     cell_key [skt_pkg::CAPACITY];
  logic [skt_pkg::CAPACITY-1:0]      lt_vec;
  logic [skt_pkg::CAPACITY-1:0]      eq_vec;
  logic [skt_pkg::CAPACITY:0]        bnd_vec;
  skt_pkg::pos_t                     enc_pos;
  logic                              enc_found;
  logic                              in_fire;
  logic                              upd_fire;
  logic [1:0]                        res_status;
  logic                              ins_ok;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid & ~in_stall;
  assign upd_fire = (state_r == S_UPD) & (~out_valid_r | ~out_stall);

  always_comb begin
    res_status = skt_pkg::ST_OK;
    if (cmd_r == skt_pkg::CMD_INSERT) begin
      if (enc_found && unique_r) begin
        res_status = skt_pkg::ST_DUP;
      end else if (count_r == skt_pkg::POS_W'(skt_pkg::CAPACITY)) begin
        res_status = skt_pkg::ST_FULL;
      end
    end
  end

  assign ins_ok     = (cmd_r == skt_pkg::CMD_INSERT) & (res_status == skt_pkg::ST_OK);
  assign ctl.cmp_en = (state_r == S_CMP);
  assign ctl.ins_en = upd_fire & ins_ok;

  generate
    for (genvar g = 0; g < skt_pkg::CAPACITY; g++) begin : g_cell
      skt_pkg::key_t prev_key;
      logic          prev_lt;
      if (g == 0) begin : g_first
        assign prev_key = req_key_r;
        assign prev_lt  = 1'b1;
      end else begin : g_rest
        assign prev_key = cell_key[g-1];
        assign prev_lt  = lt_vec[g-1];
      end
      skt_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .cell_idx (skt_pkg::POS_W'(g)),
        .count    (count_r),
        .req_key  (req_key_r),
        .prev_key (prev_key),
        .prev_lt  (prev_lt),
        .key_out  (cell_key[g]),
        .lt_out   (lt_vec[g]),
        .eq_out   (eq_vec[g]),
        .bnd_out  (bnd_vec[g])
      );
    end
  endgenerate

  // every cell holds a key below the request key: insert point is past the last cell
  assign bnd_vec[skt_pkg::CAPACITY] = lt_vec[skt_pkg::CAPACITY-1];

  skt_encoder u_enc (
    .bnd      (bnd_vec),
    .eq       (eq_vec),
    .position (enc_pos),
    .found    (enc_found)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_fire) begin
          state_nxt = S_IDLE;
          if (ins_ok) begin
            count_nxt = count_r + skt_pkg::POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      unique_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        unique_r <= cfg_wdata;
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= in_cmd;
      req_key_r <= in_key[skt_pkg::KEY_W-1:0];
    end
    if (upd_fire) begin
      out_found_r  <= enc_found;
      out_pos_r    <= enc_pos;
      out_status_r <= res_status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = 7'(out_pos_r);
  assign out_status   = out_status_r;

  `SKT_ASSERT(a_count_cap, count_r <= skt_pkg::POS_W'(skt_pkg::CAPACITY))
  `SKT_ASSERT(a_bnd_onehot, (state_r != S_UPD) || $onehot(bnd_vec))
  `SKT_ASSERT_NEXT(a_count_inc, upd_fire && ins_ok, count_r == $past(count_r) + skt_pkg::POS_W'(1))
  `SKT_ASSERT(a_full_status, !(upd_fire && res_status == skt_pkg::ST_FULL) || (count_r == skt_pkg::POS_W'(skt_pkg::CAPACITY)))
  `SKT_ASSERT_NEXT(a_result_load, upd_fire, out_valid_r && state_r == S_IDLE)

endmodule
